### hw/rtl/bba_pkg.sv
// bba_pkg: shared types and constants of the bitmap block allocator
// no dependencies
`default_nettype none
package bba_pkg;
   localparam int FUNC_W   = 3;
   localparam int ADDR_W   = 24;
   localparam int COUNT_W  = 13;
   localparam int CSR_W    = 15;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_INIT        = 3'd0,
      FUNC_ALLOC       = 3'd1,
      FUNC_FREE        = 3'd2,
      FUNC_REGION_FREE = 3'd3,
      FUNC_REGION_USED = 3'd4
   } func_type;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic [ADDR_W-1:0] byte_address;
      logic [ADDR_W-1:0] region_bytes;
   } req_type;

   typedef struct packed {
      logic [ADDR_W-1:0]  block_address;
      logic               status;
      logic [COUNT_W-1:0] used_count;
   } rsp_type;
endpackage
`default_nettype wire

### hw/rtl/bba_req_if.sv
// bba_req_if: request channel, valid/ready with request payload
// depends on bba_pkg
`default_nettype none
interface bba_req_if;
   logic                      valid;
   logic                      ready;
   logic [bba_pkg::FUNC_W-1:0] func;
   logic [bba_pkg::ADDR_W-1:0] byte_address;
   logic [bba_pkg::ADDR_W-1:0] region_bytes;
   modport source (output valid, func, byte_address, region_bytes, input ready);
   modport sink   (input valid, func, byte_address, region_bytes, output ready);
endinterface
`default_nettype wire

### hw/rtl/bba_rsp_if.sv
// bba_rsp_if: response channel, valid/ready with response payload
// depends on bba_pkg
`default_nettype none
interface bba_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [bba_pkg::ADDR_W-1:0]  block_address;
   logic                        status;
   logic [bba_pkg::COUNT_W-1:0] used_count;
   modport source (output valid, block_address, status, used_count, input ready);
   modport sink   (input valid, block_address, status, used_count, output ready);
endinterface
`default_nettype wire

### hw/rtl/bba_ram.sv
// bba_ram: generic single-port-write, single-port-read ram, registered read
// no dependencies
`default_nettype none
module bba_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

### hw/rtl/bba_front.sv
// bba_front: request queue, accepts requests and passes them on in order
// depends on bba_pkg
`default_nettype none
module bba_front #(
   parameter int DEPTH       = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   output      logic             in_ready,
   input  wire bba_pkg::req_type in_req,
   output      logic             out_valid,
   input  wire logic             out_ready,
   output      bba_pkg::req_type out_req
);
   import bba_pkg::*;
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   req_type         q_ff [DEPTH];
   logic [PW-1:0]   wp_ff, wp_in, rp_ff, rp_in;
   logic [PW:0]     cnt_ff, cnt_in;
   logic            push, pop;

   assign in_ready  = (cnt_ff != PW'(0) + (PW+1)'(DEPTH));
   assign out_valid = (cnt_ff != '0);
   assign out_req   = q_ff[rp_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wp_in  = push ? ((wp_ff == PW'(DEPTH-1)) ? '0 : wp_ff + PW'(1)) : wp_ff;
      rp_in  = pop  ? ((rp_ff == PW'(DEPTH-1)) ? '0 : rp_ff + PW'(1)) : rp_ff;
      cnt_in = cnt_ff + (PW+1)'(push) - (PW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         q_ff[wp_ff] <= in_req;
      end
   end
endmodule
`default_nettype wire

### hw/rtl/bba_back.sv
// bba_back: executes allocator operations over the bitmap ram
// depends on bba_pkg, bba_ram
`default_nettype none
module bba_back #(
   parameter int BLOCK_BYTES = 4096,
   parameter int MAX_BLOCKS  = 4096,
   parameter int WORD_BITS   = 32
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic [bba_pkg::CSR_W-1:0]   mem_kb,
   input  wire logic                        in_valid,
   output      logic                        in_ready,
   input  wire bba_pkg::req_type            in_req,
   output      logic                        out_valid,
   input  wire logic                        out_ready,
   output      bba_pkg::rsp_type            out_rsp
);
   import bba_pkg::*;
   localparam int WORDS = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
   localparam int WA    = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int BW    = $clog2(WORD_BITS);
   localparam int BKW   = $clog2(MAX_BLOCKS + 1);
   localparam int SH    = $clog2(BLOCK_BYTES);
   localparam int IXW   = (ADDR_W - SH > 0) ? ADDR_W - SH : 1;
   localparam int BXW   = (IXW > BKW) ? IXW + 1 : BKW + 1;

   typedef enum logic [3:0] {
      ST_IDLE, ST_CLEAR, ST_INIT, ST_ARD, ST_AWAIT, ST_ACHK,
      ST_RRD, ST_RWAIT, ST_RWR, ST_ZRD, ST_ZWAIT, ST_ZWR, ST_DONE
   } state_type;

   state_type            state_ff;
   logic [WA:0]          widx_ff;
   logic [BXW-1:0]       blk_ff, left_ff;
   logic [COUNT_W-1:0]   used_ff;
   logic [BKW-1:0]       limit_ff;
   logic                 mark_ff, zero_ff, found_ff;
   rsp_type              rsp_ff;
   logic                 rsp_valid_ff;

   logic                 wr_en;
   logic [WA-1:0]        wr_addr, rd_addr;
   logic [WORD_BITS-1:0] wr_data, rd_data;
   logic [31:0]          lim_raw;
   logic [BW:0]          first_free;
   logic [BKW+BW:0]      cand;

   bba_ram #(.WIDTH(WORD_BITS), .DEPTH(WORDS)) u_ram (
      .clock, .wr_en, .wr_addr, .wr_data, .rd_addr, .rd_data
   );

   assign lim_raw = ({17'd0, mem_kb} << 10) >> SH;

   always_comb begin
      first_free = BW'(0) + (BW+1)'(WORD_BITS);
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (!rd_data[i]) first_free = (BW+1)'(i);
      end
      cand = (BKW+BW+1)'(widx_ff[WA-1:0]) * (BKW+BW+1)'(WORD_BITS)
           + (BKW+BW+1)'(first_free);
   end

   assign in_ready  = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign out_valid = rsp_valid_ff;
   assign out_rsp   = rsp_ff;

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = widx_ff[WA-1:0];
      wr_data = rd_data;
      rd_addr = widx_ff[WA-1:0];
      unique case (state_ff)
         ST_CLEAR, ST_INIT: begin
            wr_en   = 1'b1;
            wr_data = '1;
         end
         ST_ACHK: begin
            if (!found_ff && first_free != (BW+1)'(WORD_BITS)
                && cand < (BKW+BW+1)'(limit_ff)) begin
               wr_en   = 1'b1;
               wr_data = rd_data | (WORD_BITS'(1) << first_free[BW-1:0]);
            end
         end
         ST_RRD, ST_RWAIT, ST_RWR: begin
            rd_addr = WA'(blk_ff >> BW);
            wr_addr = WA'(blk_ff >> BW);
            if (state_ff == ST_RWR && blk_ff < BXW'(limit_ff)) begin
               wr_en = 1'b1;
               if (mark_ff) wr_data = rd_data | (WORD_BITS'(1) << blk_ff[BW-1:0]);
               else         wr_data = rd_data & ~(WORD_BITS'(1) << blk_ff[BW-1:0]);
            end
         end
         ST_ZRD, ST_ZWAIT, ST_ZWR: begin
            rd_addr = '0;
            wr_addr = '0;
            if (state_ff == ST_ZWR) begin
               wr_en   = 1'b1;
               wr_data = rd_data | WORD_BITS'(1);
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         widx_ff      <= '0;
         used_ff      <= COUNT_W'(MAX_BLOCKS);
         rsp_valid_ff <= 1'b0;
         found_ff     <= 1'b0;
      end else begin
         if (rsp_valid_ff && out_ready) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_CLEAR, ST_INIT: begin
               widx_ff <= widx_ff + 1'b1;
               if (widx_ff == (WA+1)'(WORDS - 1)) begin
                  state_ff <= (state_ff == ST_CLEAR) ? ST_IDLE : ST_DONE;
               end
            end
            ST_IDLE: begin
               if (in_valid && in_ready) begin
                  limit_ff <= (lim_raw > 32'(MAX_BLOCKS)) ? BKW'(MAX_BLOCKS)
                                                          : BKW'(lim_raw);
                  rsp_ff.block_address <= '0;
                  rsp_ff.status        <= 1'b0;
                  widx_ff  <= '0;
                  found_ff <= 1'b0;
                  blk_ff   <= BXW'(in_req.byte_address >> SH);
                  left_ff  <= BXW'(in_req.region_bytes >> SH);
                  mark_ff  <= (in_req.func == FUNC_REGION_USED);
                  zero_ff  <= (in_req.func == FUNC_REGION_FREE);
                  unique case (in_req.func)
                     FUNC_INIT: state_ff <= ST_INIT;
                     FUNC_ALLOC: state_ff <= ST_ARD;
                     FUNC_FREE: begin
                        left_ff  <= BXW'(1);
                        state_ff <= ST_RRD;
                     end
                     FUNC_REGION_FREE, FUNC_REGION_USED: state_ff <= ST_RRD;
                     default: state_ff <= ST_DONE;
                  endcase
               end
            end
            ST_ARD: begin
               if ({1'b0, used_ff} >= (COUNT_W+1)'(limit_ff) ||
                   (BKW+BW+1)'(widx_ff) * (BKW+BW+1)'(WORD_BITS)
                   >= (BKW+BW+1)'(limit_ff) || widx_ff == (WA+1)'(WORDS)) begin
                  rsp_ff.status <= 1'b1;
                  state_ff      <= ST_DONE;
               end else begin
                  state_ff <= ST_AWAIT;
               end
            end
            ST_AWAIT: state_ff <= ST_ACHK;
            ST_ACHK: begin
               if (first_free != (BW+1)'(WORD_BITS)) begin
                  if (cand < (BKW+BW+1)'(limit_ff)) begin
                     rsp_ff.block_address <= ADDR_W'(cand) << SH;
                     if (used_ff < COUNT_W'(MAX_BLOCKS)) used_ff <= used_ff + 1'b1;
                  end else begin
                     rsp_ff.status <= 1'b1;
                  end
                  state_ff <= ST_DONE;
               end else begin
                  widx_ff  <= widx_ff + 1'b1;
                  state_ff <= ST_ARD;
               end
            end
            ST_RRD: begin
               if (left_ff == '0) state_ff <= zero_ff ? ST_ZRD : ST_DONE;
               else               state_ff <= ST_RWAIT;
            end
            ST_RWAIT: state_ff <= ST_RWR;
            ST_RWR: begin
               if (blk_ff < BXW'(limit_ff)) begin
                  if (mark_ff) begin
                     if (used_ff < COUNT_W'(MAX_BLOCKS)) used_ff <= used_ff + 1'b1;
                  end else if (used_ff != '0) begin
                     used_ff <= used_ff - 1'b1;
                  end
               end
               blk_ff  <= blk_ff + 1'b1;
               left_ff <= left_ff - 1'b1;
               state_ff <= ST_RRD;
            end
            ST_ZRD:   state_ff <= ST_ZWAIT;
            ST_ZWAIT: state_ff <= ST_ZWR;
            ST_ZWR:   state_ff <= ST_DONE;
            ST_DONE: begin
               if (!rsp_valid_ff) begin
                  // count presented with the response tracks the register at completion
                  rsp_ff.used_count <= used_ff;
                  rsp_valid_ff      <= 1'b1;
                  state_ff          <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
         if (state_ff == ST_INIT && widx_ff == (WA+1)'(WORDS - 1)) begin
            used_ff <= COUNT_W'(limit_ff);
         end
      end
   end
endmodule
`default_nettype wire

### hw/rtl/bitmap_block_allocator.sv
// bitmap_block_allocator: top level of the bitmap page allocator
// depends on bba_pkg, bba_req_if, bba_rsp_if, bba_front, bba_back
//
// usage:
//   req channel carries func, byte_address, region_bytes; one request gives
//   exactly one response on the rsp channel (block_address, status,
//   used_count). csr_write_enable / csr_write_data set memory_size_kb, to be
//   written by the user only while the block is idle; the block does not enforce it.
// operation:
//   a two-entry request queue (front) feeds a bitmap engine (back) that
//   owns one ram word port with registered read.
//   init: one write per bitmap word
//   alloc: ST_ARD, ST_AWAIT, ST_ACHK per word until the first free bit
//   free: one block; region ops: ST_RRD, ST_RWAIT, ST_RWR per block walked,
//   plus a read-modify-write of block 0 for the fix-up of region free
// reset:
//   after reset the engine sweeps the ram to all ones, during which no
//   request reaches the engine (requests queue in the front)
// stalls:
//   a held response holds the engine; the front keeps taking requests
//   until its queue is full
`default_nettype none
module bitmap_block_allocator #(
   parameter int BLOCK_BYTES = 4096,
   parameter int MAX_BLOCKS  = 4096,
   parameter int WORD_BITS   = 32
) (
   input wire logic                      clock,
   input wire logic                      reset,
   bba_req_if.sink                       req,
   bba_rsp_if.source                     rsp,
   input wire logic                      csr_write_enable,
   input wire logic [bba_pkg::CSR_W-1:0] csr_write_data
);
   import bba_pkg::*;

   // memory size register, 16 MiB at reset
   logic [CSR_W-1:0] mem_kb_ff;
   req_type          req_in, q_req;
   rsp_type          rsp_out;
   logic             q_valid, q_ready;

   always_ff @(posedge clock) begin
      if (reset)                 mem_kb_ff <= CSR_W'(16384);
      else if (csr_write_enable) mem_kb_ff <= csr_write_data;
   end

   assign req_in.func         = req.func;
   assign req_in.byte_address = req.byte_address;
   assign req_in.region_bytes = req.region_bytes;

   bba_front #(.DEPTH(2)) u_front (
      .clock, .reset,
      .in_valid (req.valid), .in_ready (req.ready), .in_req (req_in),
      .out_valid(q_valid),   .out_ready(q_ready),   .out_req(q_req)
   );

   bba_back #(.BLOCK_BYTES(BLOCK_BYTES), .MAX_BLOCKS(MAX_BLOCKS),
              .WORD_BITS(WORD_BITS)) u_back (
      .clock, .reset, .mem_kb(mem_kb_ff),
      .in_valid (q_valid),   .in_ready (q_ready),   .in_req (q_req),
      .out_valid(rsp.valid), .out_ready(rsp.ready), .out_rsp(rsp_out)
   );

   assign rsp.block_address = rsp_out.block_address;
   assign rsp.status        = rsp_out.status;
   assign rsp.used_count    = rsp_out.used_count;
endmodule
`default_nettype wire

### hw/rtl/bba_checker.sv
// bba_checker: port-level checks of the allocator, bound to the top level
// depends on bba_pkg
`default_nettype none
module bba_checker (
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic                        rsp_valid,
   input wire logic                        rsp_ready,
   input wire logic                        rsp_status,
   input wire logic [bba_pkg::ADDR_W-1:0]  rsp_block_address,
   input wire logic [bba_pkg::COUNT_W-1:0] rsp_used_count
);
   import bba_pkg::*;
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid) else $error("rsp dropped");
   a_fail_addr: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status |-> rsp_block_address == '0)
      else $error("failed alloc with address");
   a_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_used_count <= COUNT_W'(4096))
      else $error("count out of range");
endmodule

bind bitmap_block_allocator bba_checker u_bba_checker (
   .clock, .reset,
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_status(rsp.status),
   .rsp_block_address(rsp.block_address), .rsp_used_count(rsp.used_count)
);
`default_nettype wire

### test/tb_bitmap_block_allocator.sv
// tb_bitmap_block_allocator: self-checking testbench of the bitmap block allocator
// depends on bba_pkg, bba_req_if, bba_rsp_if and the bitmap_block_allocator rtl
`timescale 1ns / 1ps
module tb_bitmap_block_allocator;
   import bba_pkg::*;

   localparam int BLOCK_BYTES = 4096;
   localparam int MAX_BLOCKS  = 4096;
   localparam int N_RANDOM    = 1520;
   localparam logic [FUNC_W-1:0] FUNC_UNKNOWN_LO = 3'd5;
   localparam logic [FUNC_W-1:0] FUNC_UNKNOWN_HI = 3'd7;
   localparam logic [ADDR_W-1:0] ADDR_MAX = 24'hFFFFFF;

   // one row of the directed table; typed rows carry their expected response
   typedef struct {
      logic [FUNC_W-1:0]  func;
      logic [ADDR_W-1:0]  byte_address;
      logic [ADDR_W-1:0]  region_bytes;
      bit                 typed;
      logic [ADDR_W-1:0]  block_address;
      logic               status;
      logic [COUNT_W-1:0] used_count;
   } dir_row_type;

   logic clock;
   logic reset;
   logic csr_write_enable;
   logic [CSR_W-1:0] csr_write_data;

   bba_req_if req_ch();
   bba_rsp_if rsp_ch();

   bitmap_block_allocator dut (
      .clock            (clock),
      .reset            (reset),
      .req              (req_ch),
      .rsp              (rsp_ch),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   // shadow copy of the allocator state
   logic [MAX_BLOCKS-1:0] shadow_bitmap;
   int unsigned           shadow_used;
   int unsigned           shadow_mem_kb;

   rsp_type            pending_rsp[$];
   logic [ADDR_W-1:0]  granted_addrs[$];
   int unsigned        rsp_seen;
   bit                 failed;
   bit                 sender_idles;
   bit                 receiver_idles;
   bit                 hold_off;
   dir_row_type        dir_tab[16];

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // run limit, far above the slowest legal run
   initial begin
      #200ms;
      $display("[FAIL] regression broken");
      $finish;
   end

   function automatic int unsigned block_count();
      int unsigned n;
      n = (shadow_mem_kb * 1024) / BLOCK_BYTES;
      return (n > MAX_BLOCKS) ? MAX_BLOCKS : n;
   endfunction

   // walk a run of blocks, skipping those past the managed memory
   function automatic void mark_run(input logic [ADDR_W-1:0] base,
                                    input logic [ADDR_W-1:0] len, input bit mark);
      int unsigned first, n, b, lim;
      first = base / BLOCK_BYTES;
      n     = len / BLOCK_BYTES;
      lim   = block_count();
      for (int unsigned k = 0; k < n; k++) begin
         b = first + k;
         if (b < lim) begin
            shadow_bitmap[b] = mark;
            if (mark) begin
               if (shadow_used < MAX_BLOCKS) shadow_used++;
            end else begin
               if (shadow_used > 0) shadow_used--;
            end
         end
      end
   endfunction

   // advance the shadow state by one request and return the response it gives
   function automatic rsp_type predict_alloc_result(input req_type r);
      rsp_type     o;
      int unsigned lim, b;
      bit          found;
      lim   = block_count();
      found = 1'b0;
      b     = 0;
      o.block_address = '0;
      o.status        = 1'b0;
      case (r.func)
         FUNC_INIT: begin
            shadow_bitmap = '1;
            shadow_used   = lim;
         end
         FUNC_ALLOC: begin
            // lowest clear bit below the block count
            if (shadow_used < lim) begin
               for (int unsigned c = 0; c < lim && !found; c++) begin
                  if (!shadow_bitmap[c]) begin
                     b     = c;
                     found = 1'b1;
                  end
               end
            end
            if (found) begin
               shadow_bitmap[b] = 1'b1;
               if (shadow_used < MAX_BLOCKS) shadow_used++;
               o.block_address = ADDR_W'(b * BLOCK_BYTES);
            end else begin
               o.status = 1'b1;
            end
         end
         FUNC_FREE: begin
            b = r.byte_address / BLOCK_BYTES;
            if (b < lim) begin
               shadow_bitmap[b] = 1'b0;
               if (shadow_used > 0) shadow_used--;
            end
         end
         FUNC_REGION_FREE: begin
            mark_run(r.byte_address, r.region_bytes, 1'b0);
            // block 0 goes back to used, count untouched
            shadow_bitmap[0] = 1'b1;
         end
         FUNC_REGION_USED: mark_run(r.byte_address, r.region_bytes, 1'b1);
         default: ;
      endcase
      o.used_count = COUNT_W'(shadow_used);
      return o;
   endfunction

   // offer one request, wait for its handshake, then queue what it should return
   task automatic send_request(input req_type r, input bit typed, input rsp_type typed_rsp);
      int      gap;
      rsp_type p;
      gap = sender_idles ? $urandom_range(0, 15) : 0;
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.func         <= r.func;
      req_ch.byte_address <= r.byte_address;
      req_ch.region_bytes <= r.region_bytes;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      p = predict_alloc_result(r);
      if (typed) pending_rsp.push_back(typed_rsp);
      else pending_rsp.push_back(p);
      if (r.func == FUNC_ALLOC && !p.status) granted_addrs.push_back(p.block_address);
   endtask

   // memory size changes only with the allocator drained
   task automatic write_mem_size(input int unsigned kb);
      req_ch.valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= CSR_W'(kb);
      @(posedge clock);
      csr_write_enable <= 1'b0;
      shadow_mem_kb = kb & 32'h7FFF;
      granted_addrs.delete();
   endtask

   // mostly well-formed traffic: allocs, frees of granted blocks, short regions
   function automatic req_type random_request();
      req_type     r;
      int unsigned sel, idx, lim;
      lim = block_count();
      sel = $urandom_range(0, 99);
      r.byte_address = ADDR_W'($urandom());
      r.region_bytes = ADDR_W'($urandom_range(0, 6) * BLOCK_BYTES + $urandom_range(0, 4095));
      if (sel < 3) begin
         r.func = FUNC_INIT;
      end else if (sel < 40) begin
         r.func = FUNC_ALLOC;
      end else if (sel < 62 && granted_addrs.size() != 0) begin
         r.func = FUNC_FREE;
         idx = $urandom_range(0, granted_addrs.size() - 1);
         r.byte_address = granted_addrs[idx] | ADDR_W'($urandom_range(0, 4095));
         granted_addrs.delete(idx);
      end else if (sel < 70) begin
         r.func = FUNC_FREE;
         r.byte_address = ADDR_W'($urandom_range(0, lim + 3) * BLOCK_BYTES
                                  + $urandom_range(0, 4095));
      end else if (sel < 90) begin
         // short region near the managed memory, sometimes crossing its end
         r.func = (sel < 80) ? FUNC_REGION_FREE : FUNC_REGION_USED;
         r.byte_address = ADDR_W'($urandom_range(0, lim + 3) * BLOCK_BYTES
                                  + $urandom_range(0, 4095));
      end else if (sel < 92) begin
         // rare long region with raw fields
         r.func = (sel == 90) ? FUNC_REGION_FREE : FUNC_REGION_USED;
         r.region_bytes = ADDR_W'($urandom());
      end else if (sel < 95) begin
         r.func = FUNC_W'($urandom_range(FUNC_UNKNOWN_LO, FUNC_UNKNOWN_HI));
      end else begin
         r.func = FUNC_FREE;
      end
      return r;
   endfunction

   // stimulus
   initial begin
      req_type     r;
      rsp_type     t;
      int unsigned mem_plan[8];
      int unsigned lim;
      req_ch.valid        <= 1'b0;
      req_ch.func         <= FUNC_INIT;
      req_ch.byte_address <= '0;
      req_ch.region_bytes <= '0;
      csr_write_enable    <= 1'b0;
      csr_write_data      <= '0;
      reset               <= 1'b1;
      shadow_bitmap  = '1;
      shadow_used    = MAX_BLOCKS;
      shadow_mem_kb  = 16384;
      failed         = 1'b0;
      sender_idles   = 1'b1;
      receiver_idles = 1'b1;
      mem_plan = '{16384, 0, 4, 128, 132, 32767, 5, 0};
      mem_plan[7] = $urandom_range(0, 32767);

      // directed table: reset state, full memory, saturation, edges of the map
      dir_tab[0]  = '{FUNC_ALLOC,       24'h0,      24'h0,      1, 24'h0,      1, 4096};
      dir_tab[1]  = '{FUNC_UNKNOWN_HI,  ADDR_MAX,   ADDR_MAX,   1, 24'h0,      0, 4096};
      dir_tab[2]  = '{FUNC_FREE,        ADDR_MAX,   24'h0,      1, 24'h0,      0, 4095};
      dir_tab[3]  = '{FUNC_ALLOC,       24'h0,      24'h0,      1, 24'hFFF000, 0, 4096};
      dir_tab[4]  = '{FUNC_REGION_FREE, 24'h0,      24'h2000,   1, 24'h0,      0, 4094};
      dir_tab[5]  = '{FUNC_ALLOC,       24'h0,      24'h0,      1, 24'h1000,   0, 4095};
      dir_tab[6]  = '{FUNC_REGION_USED, 24'h0,      24'h3000,   1, 24'h0,      0, 4096};
      dir_tab[7]  = '{FUNC_INIT,        24'h0,      24'h0,      1, 24'h0,      0, 4096};
      dir_tab[8]  = '{FUNC_FREE,        24'h5000,   24'h0,      1, 24'h0,      0, 4095};
      dir_tab[9]  = '{FUNC_FREE,        24'h5FFF,   24'h0,      1, 24'h0,      0, 4094};
      dir_tab[10] = '{FUNC_REGION_FREE, 24'hFFE000, ADDR_MAX,   1, 24'h0,      0, 4092};
      dir_tab[11] = '{FUNC_REGION_FREE, 24'h0,      ADDR_MAX,   1, 24'h0,      0, 0};
      dir_tab[12] = '{FUNC_ALLOC,       24'h0,      24'h0,      1, 24'h1000,   0, 1};
      dir_tab[13] = '{FUNC_REGION_USED, 24'h0,      24'h0,      1, 24'h0,      0, 1};
      dir_tab[14] = '{FUNC_FREE,        24'h0,      24'h0,      1, 24'h0,      0, 0};
      dir_tab[15] = '{FUNC_ALLOC,       24'h0,      24'h0,      0, 24'h0,      0, 0};

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_tab[i]) begin
         r.func         = dir_tab[i].func;
         r.byte_address = dir_tab[i].byte_address;
         r.region_bytes = dir_tab[i].region_bytes;
         t.block_address = dir_tab[i].block_address;
         t.status        = dir_tab[i].status;
         t.used_count    = dir_tab[i].used_count;
         send_request(r, dir_tab[i].typed, t);
      end

      // random phases, one memory size each, extremes included
      for (int ph = 0; ph < 8; ph++) begin
         write_mem_size(mem_plan[ph]);
         sender_idles   = (ph % 3) != 1;
         receiver_idles = (ph % 3) != 2;
         lim = block_count();
         // open up the whole managed memory first
         r.func         = FUNC_REGION_FREE;
         r.byte_address = '0;
         r.region_bytes = (lim * BLOCK_BYTES > ADDR_MAX) ? ADDR_MAX
                                                         : ADDR_W'(lim * BLOCK_BYTES);
         send_request(r, 1'b0, t);
         for (int k = 0; k < N_RANDOM / 8; k++)
            send_request(random_request(), 1'b0, t);
      end
      req_ch.valid <= 1'b0;

      // drain, then let the engine settle
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (!failed)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   // one long hold-off of the receiver so the request queue backs up
   initial begin
      hold_off = 1'b0;
      wait (rsp_seen == 150);
      hold_off = 1'b1;
      repeat (400) @(posedge clock);
      hold_off = 1'b0;
   end

   // response side: random stalls, plus the long hold-off above
   initial begin
      int      stall;
      rsp_type exp_rsp;
      rsp_seen = 0;
      rsp_ch.ready <= 1'b0;
      @(negedge reset);
      forever begin
         stall = receiver_idles ? $urandom_range(0, 15) : 0;
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         if (hold_off) begin
            rsp_ch.ready <= 1'b0;
            while (hold_off) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_ch.valid) @(posedge clock);
         rsp_seen++;
         if (pending_rsp.size() == 0) begin
            $error("response with no request outstanding");
            failed = 1'b1;
         end else begin
            exp_rsp = pending_rsp.pop_front();
            if (rsp_ch.block_address !== exp_rsp.block_address) begin
               $error("block_address expected %h got %h",
                      exp_rsp.block_address, rsp_ch.block_address);
               failed = 1'b1;
            end
            if (rsp_ch.status !== exp_rsp.status) begin
               $error("status expected %b got %b", exp_rsp.status, rsp_ch.status);
               failed = 1'b1;
            end
            if (rsp_ch.used_count !== exp_rsp.used_count) begin
               $error("used_count expected %0d got %0d",
                      exp_rsp.used_count, rsp_ch.used_count);
               failed = 1'b1;
            end
         end
      end
   end
endmodule
